// ===== hw/rtl/usbcsr_pkg.sv =====
// Package: codes, types and widths for the USB standard request handler.
`timescale 1ns / 1ps

package usbcsr_pkg;

  localparam int InDataW   = 72;
  localparam int OutDataW  = 64;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 12;
  localparam int LenW      = 12;

  // register indexes on the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    REG_DEVICE_DESC_LEN = 3'd0,
    REG_CONFIG_DESC_LEN = 3'd1,
    REG_STRING0_LEN     = 3'd2,
    REG_STRING1_LEN     = 3'd3,
    REG_STRING2_LEN     = 3'd4,
    REG_STRING3_LEN     = 3'd5,
    REG_NUM_CONFIGS     = 3'd6,
    REG_SELF_POWERED    = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    OUT_OK    = 2'd0,
    OUT_ERR   = 2'd1,
    OUT_UNSUP = 2'd2,
    OUT_IN    = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ACT_VALID = 2'd0,
    ACT_STALL = 2'd1,
    ACT_KEEP  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    SRC_NONE   = 3'd0,
    SRC_ZLP    = 3'd1,
    SRC_DEV    = 3'd2,
    SRC_CONF   = 3'd3,
    SRC_STR    = 3'd4,
    SRC_STATUS = 3'd5
  } source_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DESC  = 2'd1,
    PH_ADDR  = 2'd2,
    PH_STALL = 2'd3
  } phase_t;

  // bRequest codes
  localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC      = 8'd6;
  localparam logic [7:0] REQ_SET_DESC      = 8'd7;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE = 8'd11;
  localparam logic [7:0] REQ_SYNCH_FRAME   = 8'd12;

  // recipients (bmRequestType bits 4..0)
  localparam logic [4:0] RCP_DEVICE    = 5'd0;
  localparam logic [4:0] RCP_INTERFACE = 5'd1;
  localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

  // descriptor types (wValue high byte)
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  localparam logic [7:0] MAX_ADDRESS     = 8'd127;
  localparam logic [7:0] NUM_STRINGS     = 8'd4;
  localparam logic [7:0] DEV_DESC_RESET  = 8'd18;
  localparam logic [7:0] NUM_CFG_RESET   = 8'd1;
  localparam logic [LenW-1:0] STATUS_LEN = 12'd2;

endpackage

// ===== hw/rtl/usb_control_standard_request_handler.sv =====
// Top level: USB chapter 9 standard request handler for endpoint 0.
//
// Use:
//   s_axis carries one event per transfer: tuser[0] = 0 for a decoded setup
//   packet, 1 for a completed EP0 IN transaction. tdata holds the setup
//   fields and the halt state of the endpoint named in wIndex.
//   m_axis returns exactly one result per event: tuser carries the outcome,
//   tdata the EP0 actions, send source and length, status word, the device
//   address and configuration after the event, and an endpoint un-halt.
//   cfg_* writes descriptor lengths and device options; ready is always
//   high, and writes are meant to be made while no event is in flight.
// Timing:
//   Decode is a single combinational pass between the input handshake and
//   the output register. One event per cycle is sustained while
//   m_axis_tready is high. Handler state updates on the accepting edge, so
//   the next event sees it at once.
// Stall and reset:
//   While a result sits unread, s_axis_tready follows m_axis_tready; the
//   result register holds its contents. Synchronous reset empties the
//   output register, returns the handler state to idle with address and
//   configuration zero, and loads the register defaults.
`timescale 1ns / 1ps

module usb_control_standard_request_handler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // setup_type[7:0], request_code[15:8], value[31:16], index[47:32],
  // length[63:48], target_tx_halted[64], target_rx_halted[65], zero[71:66]
  input  logic [usbcsr_pkg::InDataW-1:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rx_action[1:0], tx_action[3:2], send_source[6:4], send_length[18:7],
  // status_word[34:19], device_address[41:35], address_enable[42],
  // unhalt[43], unhalt_endpoint[47:44], unhalt_in[48], configuration[56:49],
  // zero[63:57]
  output logic [usbcsr_pkg::OutDataW-1:0] m_axis_tdata,
  // outcome[1:0]
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [usbcsr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [usbcsr_pkg::CfgDataW-1:0]  cfg_data
);
  import usbcsr_pkg::*;

  // configuration registers
  logic [7:0]      device_desc_len;
  logic [LenW-1:0] config_desc_len;
  logic [7:0]      string_len [NUM_STRINGS];
  logic [7:0]      num_configs;
  logic            self_powered;

  // handler state
  phase_t     phase, phase_next;
  logic [6:0] pending_address, pending_address_next;
  logic [6:0] active_address, active_address_next;
  logic       address_enabled, address_enabled_next;
  logic [7:0] current_config, current_config_next;
  logic       remote_wakeup, remote_wakeup_next;

  // unpacked input fields
  logic        in_op;
  logic [7:0]  in_rtype, in_code;
  logic [15:0] in_value, in_index, in_length;
  logic        in_txh, in_rxh;
  logic        in_accept;

  // result of the decode
  outcome_t        res;
  action_t         rx_act, tx_act;
  source_t         src;
  logic [LenW-1:0] slen;
  logic [15:0]     sword;
  logic            unh, unh_in;
  logic [3:0]      unh_ep;

  // helpers
  logic [LenW-1:0] desc_len;
  source_t         desc_src;
  logic            ep_in, ep_halted;
  logic [LenW-1:0] status_len;

  assign in_rtype  = s_axis_tdata[7:0];
  assign in_code   = s_axis_tdata[15:8];
  assign in_value  = s_axis_tdata[31:16];
  assign in_index  = s_axis_tdata[47:32];
  assign in_length = s_axis_tdata[63:48];
  assign in_txh    = s_axis_tdata[64];
  assign in_rxh    = s_axis_tdata[65];
  assign in_op     = s_axis_tuser[0];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_desc_len <= DEV_DESC_RESET;
      config_desc_len <= '0;
      for (int i = 0; i < NUM_STRINGS; i++) begin
        string_len[i] <= '0;
      end
      num_configs  <= NUM_CFG_RESET;
      self_powered <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_DEVICE_DESC_LEN: device_desc_len <= cfg_data[7:0];
        REG_CONFIG_DESC_LEN: config_desc_len <= cfg_data;
        REG_STRING0_LEN:     string_len[0] <= cfg_data[7:0];
        REG_STRING1_LEN:     string_len[1] <= cfg_data[7:0];
        REG_STRING2_LEN:     string_len[2] <= cfg_data[7:0];
        REG_STRING3_LEN:     string_len[3] <= cfg_data[7:0];
        REG_NUM_CONFIGS:     num_configs <= cfg_data[7:0];
        REG_SELF_POWERED:    self_powered <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // descriptor lookup by wValue
  always_comb begin
    desc_len = '0;
    desc_src = SRC_NONE;
    case (in_value[15:8])
      DESC_DEVICE: begin
        desc_len = {4'b0, device_desc_len};
        desc_src = SRC_DEV;
      end
      DESC_CONFIG: begin
        desc_len = config_desc_len;
        desc_src = SRC_CONF;
      end
      DESC_STRING: begin
        desc_src = SRC_STR;
        if (in_value[7:0] < NUM_STRINGS) begin
          desc_len = {4'b0, string_len[in_value[1:0]]};
        end
      end
      default: ;
    endcase
  end

  assign ep_in      = in_index[7];
  assign ep_halted  = ep_in ? in_txh : in_rxh;
  assign status_len = (in_length < 16'(STATUS_LEN)) ? in_length[LenW-1:0] : STATUS_LEN;

  // single pass decode and state update
  always_comb begin
    res    = OUT_OK;
    rx_act = ACT_VALID;
    tx_act = ACT_VALID;
    src    = SRC_NONE;
    slen   = '0;
    sword  = '0;
    unh    = 1'b0;
    unh_ep = '0;
    unh_in = 1'b0;

    phase_next           = phase;
    pending_address_next = pending_address;
    active_address_next  = active_address;
    address_enabled_next = address_enabled;
    current_config_next  = current_config;
    remote_wakeup_next   = remote_wakeup;

    if (in_op) begin
      res    = OUT_IN;
      rx_act = ACT_KEEP;
      tx_act = ACT_KEEP;
      if (phase == PH_DESC) begin
        tx_act = ACT_STALL;
      end else if (phase == PH_ADDR) begin
        active_address_next  = pending_address;
        address_enabled_next = 1'b1;
      end
      phase_next = PH_IDLE;
    end else begin
      phase_next = PH_IDLE;
      if (in_rtype[6:5] != 2'b00) begin
        res = OUT_UNSUP;
      end else begin
        case (in_rtype[4:0])
          RCP_DEVICE: begin
            case (in_code)
              REQ_GET_STATUS: begin
                src   = SRC_STATUS;
                slen  = status_len;
                sword = {14'b0, remote_wakeup, self_powered};
              end
              REQ_CLEAR_FEATURE: begin
                if (in_value[0]) remote_wakeup_next = 1'b0;
                src = SRC_ZLP;
              end
              REQ_SET_FEATURE: begin
                if (in_value[0]) remote_wakeup_next = 1'b1;
                src = SRC_ZLP;
              end
              REQ_SET_ADDRESS: begin
                if (in_value[7:0] > MAX_ADDRESS || in_value[15:8] != 8'd0 ||
                    in_index != 16'd0) begin
                  phase_next = PH_STALL;
                  res        = OUT_ERR;
                end else begin
                  pending_address_next = in_value[6:0];
                  phase_next           = PH_ADDR;
                  src                  = SRC_ZLP;
                end
              end
              REQ_GET_DESC: begin
                if (desc_len == '0) begin
                  res = OUT_ERR;
                end else begin
                  src        = desc_src;
                  slen       = ({4'b0, desc_len} > in_length) ? in_length[LenW-1:0]
                                                             : desc_len;
                  phase_next = PH_DESC;
                end
              end
              REQ_SET_DESC, REQ_GET_CONFIG: res = OUT_ERR;
              REQ_SET_CONFIG: begin
                if (in_value[7:0] <= num_configs && in_value[15:8] == 8'd0 &&
                    in_index == 16'd0) begin
                  current_config_next = in_value[7:0];
                  src                 = SRC_ZLP;
                end else begin
                  res = OUT_UNSUP;
                end
              end
              default: res = OUT_UNSUP;
            endcase
          end
          RCP_INTERFACE: begin
            case (in_code)
              REQ_GET_STATUS: begin
                src  = SRC_STATUS;
                slen = status_len;
              end
              REQ_CLEAR_FEATURE, REQ_SET_FEATURE: src = SRC_ZLP;
              REQ_GET_INTERFACE, REQ_SET_INTERFACE: res = OUT_ERR;
              default: res = OUT_UNSUP;
            endcase
          end
          RCP_ENDPOINT: begin
            case (in_code)
              REQ_GET_STATUS: begin
                src   = SRC_STATUS;
                slen  = status_len;
                sword = {15'b0, ep_halted};
              end
              REQ_CLEAR_FEATURE: begin
                if (in_value != 16'd0 || in_index[3:0] == 4'd0) begin
                  res = OUT_UNSUP;
                end else begin
                  if (ep_halted) begin
                    unh    = 1'b1;
                    unh_ep = in_index[3:0];
                    unh_in = ep_in;
                  end
                  src = SRC_ZLP;
                end
              end
              REQ_SET_FEATURE: src = SRC_ZLP;
              REQ_SYNCH_FRAME: res = OUT_ERR;
              default: res = OUT_UNSUP;
            endcase
          end
          default: res = OUT_UNSUP;
        endcase
      end

      // any failure stalls both directions and drops the reply
      if (res != OUT_OK) begin
        rx_act = ACT_STALL;
        tx_act = ACT_STALL;
        src    = SRC_NONE;
        slen   = '0;
        sword  = '0;
        unh    = 1'b0;
        unh_ep = '0;
        unh_in = 1'b0;
      end
    end
  end

  // handler state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      pending_address <= '0;
      active_address  <= '0;
      address_enabled <= 1'b0;
      current_config  <= '0;
      remote_wakeup   <= 1'b0;
    end else if (in_accept) begin
      phase           <= phase_next;
      pending_address <= pending_address_next;
      active_address  <= active_address_next;
      address_enabled <= address_enabled_next;
      current_config  <= current_config_next;
      remote_wakeup   <= remote_wakeup_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_axis_tuser <= res;
      m_axis_tdata <= {7'b0, current_config_next, unh_in, unh_ep, unh,
                       address_enabled_next, active_address_next, sword, slen,
                       src, tx_act, rx_act};
    end
  end

`ifndef SYNTHESIS
  // a refused request never carries a reply or an un-halt
  a_fail_silent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == OUT_ERR || m_axis_tuser == OUT_UNSUP) |->
      m_axis_tdata[6:4] == SRC_NONE && !m_axis_tdata[43] &&
      m_axis_tdata[1:0] == ACT_STALL && m_axis_tdata[3:2] == ACT_STALL)
    else $error("refused request carries a reply");

  // IN completion in the address phase enables the pending address
  a_addr_apply: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_op && phase == PH_ADDR |=>
      address_enabled && active_address == $past(pending_address))
    else $error("pending address not applied");

  // an IN completion never touches the receive side
  a_in_keep_rx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == OUT_IN |-> m_axis_tdata[1:0] == ACT_KEEP)
    else $error("IN event changed the receive action");

  // every accepted event leaves the handler out of the descriptor phase
  // unless it was a successful get descriptor
  a_phase_desc: assert property (@(posedge clk) disable iff (rst)
    in_accept && (in_op || res != OUT_OK) |=> phase != PH_DESC)
    else $error("descriptor phase entered without a reply");
`endif

endmodule
